// File: hw/rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, register indexes and the gradient word that the front end
// hands to the magnitude unit of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

   // Pixel and register widths.
   localparam int PIX_W = 8;
   localparam int CSR_W = 11;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Register values after reset.
   localparam logic [CSR_W-1:0] WIDTH_RESET = 11'd640;
   localparam logic [CSR_W-1:0] HEIGHT_RESET = 11'd480;

   // Smallest frame dimension that the window allows.
   localparam int DIM_MIN = 3;

   // Gradient range is -1020..1020, so 11 signed bits.
   localparam int GRAD_W = 11;
   // A squared gradient stays below 2**20, their sum below 2**21.
   localparam int SQR_W = 2 * GRAD_W - 2;
   localparam int SUM_W = SQR_W + 1;

   // The root is only needed below 256, so the root unit sees 16 bits.
   localparam int ROOT_IN_W = 2 * PIX_W;
   localparam logic [ROOT_IN_W-1:0] ROOT_BIT_INIT = 16'h4000;
   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   // Gradient queue between front end and magnitude unit.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // One interior window, reduced to its two gradients.
   typedef struct packed {
      logic signed [GRAD_W-1:0] gv;
      logic signed [GRAD_W-1:0] gh;
      logic                     frame_end;
   } grad_type;

endpackage

// File: hw/rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read are independent; read data is registered and appears in the cycle after the read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// Front end: raster counters, the two line stores, the 3x3 window and the
// two Sobel gradients of every interior window.
// ----------------------------------------------------------------------------
module sem_front #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sem_pkg::CSR_W-1:0]     image_width,
   input  logic [sem_pkg::CSR_W-1:0]     image_height,
   input  logic                          restart,
   input  logic                          req_push,
   input  logic [sem_pkg::PIX_W-1:0]     req_pixel,
   output logic                          req_full,
   input  logic [sem_pkg::QCNT_W-1:0]    queue_count,
   output logic                          grad_push,
   output sem_pkg::grad_type             grad_word
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WDIM_W = ($clog2(MAX_WIDTH + 1) > sem_pkg::CSR_W) ?
                           $clog2(MAX_WIDTH + 1) : sem_pkg::CSR_W;
   localparam int HDIM_W = ($clog2(MAX_HEIGHT + 1) > sem_pkg::CSR_W) ?
                           $clog2(MAX_HEIGHT + 1) : sem_pkg::CSR_W;
   localparam logic [WDIM_W-1:0] W_MAX = WDIM_W'(MAX_WIDTH);
   localparam logic [HDIM_W-1:0] H_MAX = HDIM_W'(MAX_HEIGHT);
   localparam logic [WDIM_W-1:0] W_MIN = WDIM_W'(sem_pkg::DIM_MIN);
   localparam logic [HDIM_W-1:0] H_MIN = HDIM_W'(sem_pkg::DIM_MIN);
   localparam int PW = sem_pkg::PIX_W;

   logic [WDIM_W-1:0] width_ext, width_eff;
   logic [HDIM_W-1:0] height_ext, height_eff;
   logic [COL_W-1:0]  last_col;
   logic [ROW_W-1:0]  last_row;
   logic              accept;
   logic [sem_pkg::QCNT_W-1:0] inflight;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff;
   logic [PW-1:0]    s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_interior_ff;
   logic             s1_last_ff;

   logic             s2_valid_ff;
   logic             s2_last_ff;
   logic [PW-1:0]    window_ff [9];

   logic [PW-1:0]    line_a_rd, line_b_rd;

   logic [PW+1:0]    sum_top, sum_bot, sum_left, sum_right;

   // Geometry clamped to the window minimum and the store depth.
   always_comb begin
      width_ext = WDIM_W'(image_width);
      height_ext = HDIM_W'(image_height);
      priority if (width_ext < W_MIN) width_eff = W_MIN;
      else if (width_ext > W_MAX) width_eff = W_MAX;
      else width_eff = width_ext;
      priority if (height_ext < H_MIN) height_eff = H_MIN;
      else if (height_ext > H_MAX) height_eff = H_MAX;
      else height_eff = height_ext;
   end

   assign last_col = COL_W'(width_eff - WDIM_W'(1));
   assign last_row = ROW_W'(height_eff - HDIM_W'(1));

   // Every word in the pipe may land in the queue, so count them all.
   assign inflight = queue_count + sem_pkg::QCNT_W'(s1_valid_ff)
                   + sem_pkg::QCNT_W'(s2_valid_ff);
   assign req_full = (inflight >= sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH));
   assign accept = req_push && !req_full;

   // Raster position of the next pixel.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Line stores: newest row in store A, the row before in store B.
   sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_a_rd)
   );

   sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_a_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_b_rd)
   );

   // Counters, read stage and window shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff && s1_interior_ff;
         if (s1_valid_ff) begin
            for (int k = 0; k < 3; k++) begin
               window_ff[k*3+0] <= window_ff[k*3+1];
               window_ff[k*3+1] <= window_ff[k*3+2];
            end
            window_ff[2] <= line_b_rd;
            window_ff[5] <= line_a_rd;
            window_ff[8] <= s1_pixel_ff;
         end
      end
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff <= col_ff;
         s1_interior_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_last_ff <= (row_ff == last_row) && (col_ff == last_col);
      end
      if (s1_valid_ff) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   // Weighted row and column sums of the window, then the two differences.
   always_comb begin
      sum_top = (PW+2)'(window_ff[0]) + {1'b0, window_ff[1], 1'b0}
              + (PW+2)'(window_ff[2]);
      sum_bot = (PW+2)'(window_ff[6]) + {1'b0, window_ff[7], 1'b0}
              + (PW+2)'(window_ff[8]);
      sum_left = (PW+2)'(window_ff[0]) + {1'b0, window_ff[3], 1'b0}
               + (PW+2)'(window_ff[6]);
      sum_right = (PW+2)'(window_ff[2]) + {1'b0, window_ff[5], 1'b0}
                + (PW+2)'(window_ff[8]);
      grad_word.gv = signed'({1'b0, sum_top}) - signed'({1'b0, sum_bot});
      grad_word.gh = signed'({1'b0, sum_left}) - signed'({1'b0, sum_right});
      grad_word.frame_end = s2_last_ff;
   end

   assign grad_push = s2_valid_ff;

endmodule

// File: hw/rtl/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// Short gradient queue that decouples the front end from the magnitude unit.
// ----------------------------------------------------------------------------
module sem_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sem_pkg::grad_type          push_word,
   input  logic                       pop,
   output logic                       head_valid,
   output sem_pkg::grad_type          head_word,
   output logic [sem_pkg::QCNT_W-1:0] count
);

   sem_pkg::grad_type                entry_ff [sem_pkg::QUEUE_DEPTH];
   logic [sem_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [sem_pkg::QCNT_W-1:0]       count_ff;
   logic                             do_push, do_pop;

   assign do_pop = pop && (count_ff != '0);
   assign do_push = push;

   // Pointers wrap at the queue depth; the count tracks occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == sem_pkg::QPTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + sem_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == sem_pkg::QPTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + sem_pkg::QPTR_W'(1);
         end
         count_ff <= count_ff + sem_pkg::QCNT_W'(do_push)
                   - sem_pkg::QCNT_W'(do_pop);
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_word = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// File: hw/rtl/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// Magnitude unit: squares both gradients, sums them, takes the integer
// square root one bit pair a cycle and holds the word in an output register.
// ----------------------------------------------------------------------------
module sem_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_valid,
   input  sem_pkg::grad_type         queue_word,
   output logic                      queue_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [sem_pkg::PIX_W-1:0] rsp_magnitude,
   output logic                      rsp_frame_end
);

   localparam int RW = sem_pkg::ROOT_IN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic signed [sem_pkg::GRAD_W-1:0] gv_ff, gv_in, gh_ff, gh_in;
   logic                           fe_ff, fe_in;
   logic [sem_pkg::SQR_W-1:0]      sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic                           sat_ff, sat_in;
   logic [RW-1:0]                  rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic                           out_valid_ff, out_valid_in;
   logic [sem_pkg::PIX_W-1:0]      out_mag_ff, out_mag_in;
   logic                           out_fe_ff, out_fe_in;

   logic signed [2*sem_pkg::GRAD_W-1:0] prod_v, prod_h;
   logic [sem_pkg::SUM_W-1:0]      sum_sq;
   logic [RW:0]                    trial;

   assign prod_v = gv_ff * gv_ff;
   assign prod_h = gh_ff * gh_ff;
   assign sum_sq = {1'b0, sqa_ff} + {1'b0, sqb_ff};
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   // Next state of the sequencer and its output register.
   always_comb begin
      state_in = state_ff;
      gv_in = gv_ff;
      gh_in = gh_ff;
      fe_in = fe_ff;
      sqa_in = sqa_ff;
      sqb_in = sqb_ff;
      sat_in = sat_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      out_valid_in = out_valid_ff;
      out_mag_in = out_mag_ff;
      out_fe_in = out_fe_ff;
      queue_pop = 1'b0;

      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               queue_pop = 1'b1;
               gv_in = queue_word.gv;
               gh_in = queue_word.gh;
               fe_in = queue_word.frame_end;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sqa_in = prod_v[sem_pkg::SQR_W-1:0];
            sqb_in = prod_h[sem_pkg::SQR_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Anything at or above 2**16 has a root of 256 or more.
            sat_in = |sum_sq[sem_pkg::SUM_W-1:RW];
            rem_in = sum_sq[RW-1:0];
            root_in = '0;
            bit_in = sem_pkg::ROOT_BIT_INIT;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_in = rem_ff - trial[RW-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_mag_in = sat_ff ? sem_pkg::MAG_MAX : root_ff[sem_pkg::PIX_W-1:0];
               out_fe_in = fe_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      gv_ff <= gv_in;
      gh_ff <= gh_in;
      fe_ff <= fe_in;
      sqa_ff <= sqa_in;
      sqb_ff <= sqb_in;
      sat_ff <= sat_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      out_mag_ff <= out_mag_in;
      out_fe_ff <= out_fe_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_magnitude = out_mag_ff;
   assign rsp_frame_end = out_fe_ff;

endmodule

// File: hw/rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Throughput: one pixel a cycle for border pixels while req_full is low.
// The magnitude unit takes one gradient word at a time through its 8-step
// square-root loop, and a 4-word gradient queue absorbs bursts.
// Reset is synchronous and active high: it clears the pipeline, queue and
// counters and restores 640x480; the line stores keep their contents.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [sem_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sem_pkg::CSR_W-1:0]    csr_data,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [sem_pkg::PIX_W-1:0]    req_pixel,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [sem_pkg::PIX_W-1:0]    rsp_magnitude,
   output logic                         rsp_frame_end
);

   logic [sem_pkg::CSR_W-1:0] width_ff, height_ff;
   logic                      restart;
   logic                      grad_push;
   sem_pkg::grad_type         grad_word;
   logic                      q_pop, q_valid;
   sem_pkg::grad_type         q_word;
   logic [sem_pkg::QCNT_W-1:0] q_count;

   // Geometry registers; a write to either one restarts the frame.
   assign restart = csr_write &&
                    (csr_index == sem_pkg::CSR_IMAGE_WIDTH ||
                     csr_index == sem_pkg::CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sem_pkg::WIDTH_RESET;
         height_ff <= sem_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         if (csr_index == sem_pkg::CSR_IMAGE_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_index == sem_pkg::CSR_IMAGE_HEIGHT) begin
            height_ff <= csr_data;
         end
      end
   end

   sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .restart      (restart),
      .req_push     (req_push),
      .req_pixel    (req_pixel),
      .req_full     (req_full),
      .queue_count  (q_count),
      .grad_push    (grad_push),
      .grad_word    (grad_word)
   );

   sem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grad_push),
      .push_word  (grad_word),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_word  (q_word),
      .count      (q_count)
   );

   sem_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_valid   (q_valid),
      .queue_word    (q_word),
      .queue_pop     (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_magnitude (rsp_magnitude),
      .rsp_frame_end (rsp_frame_end)
   );

   // The front end's credit check must keep the queue from overflowing.
   assert property (@(posedge clock) disable iff (reset)
      grad_push |-> (q_count < sem_pkg::QCNT_W'(sem_pkg::QUEUE_DEPTH)))
      else $error("gradient pushed into a full queue");

   // The magnitude unit only takes a word that is there.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("gradient queue popped while empty");

   // After reset no result waits and the input side is open.
   assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not idle after reset");

endmodule

// File: tb/sobel_edge_magnitude_tb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_tb
// Self-checking bench for the Sobel edge magnitude block. Pixels go in through
// the push side and magnitude words come back through the pop side. A local
// copy of the line stores, window and frame counters predicts every word.
// A short run at the reset geometry comes first, then a table of directed
// rows, then random frames of small geometry. Both sides idle at random,
// and the result side holds off for long stretches to fill the block.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM = 1024;
   localparam int RANDOM_ITEMS = 800;
   localparam int IDLE_PAUSE = 32;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DIRECTED_LEN = 33;

   // Register indexes that the block has no register behind.
   localparam logic [sem_pkg::CSR_IDX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [sem_pkg::CSR_IDX_W-1:0] CSR_UNUSED_3 = 2'd3;

   typedef struct packed {
      logic [sem_pkg::PIX_W-1:0] magnitude;
      logic                      frame_end;
   } edge_word_type;

   typedef enum logic [0:0] {STEP_CSR, STEP_PIXEL} step_kind_type;

   typedef struct packed {
      step_kind_type                 kind;
      logic [sem_pkg::CSR_IDX_W-1:0] index;
      logic [sem_pkg::CSR_W-1:0]     value;
      logic                          typed;
      edge_word_type                 word;
   } step_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_write;
   logic [sem_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sem_pkg::CSR_W-1:0]     csr_data;
   logic                          req_push;
   logic                          req_full;
   logic [sem_pkg::PIX_W-1:0]     req_pixel;
   logic                          rsp_empty;
   logic                          rsp_pop;
   logic [sem_pkg::PIX_W-1:0]     rsp_magnitude;
   logic                          rsp_frame_end;

   // Predicted state of the block.
   logic [sem_pkg::CSR_W-1:0] width_reg;
   logic [sem_pkg::CSR_W-1:0] height_reg;
   logic [sem_pkg::PIX_W-1:0] line_prev [MAX_DIM];
   logic [sem_pkg::PIX_W-1:0] line_prev2 [MAX_DIM];
   logic [sem_pkg::PIX_W-1:0] window [9];
   int unsigned               col_pos;
   int unsigned               row_pos;

   edge_word_type magnitude_expected [$];
   step_type      directed_steps [DIRECTED_LEN];
   int            mismatch_count;
   int            words_popped;
   int            cycle_count;
   bit            feed_steady;

   sobel_edge_magnitude u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_pixel     (req_pixel),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_magnitude (rsp_magnitude),
      .rsp_frame_end (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Frame geometry as the block uses it: clamped to the window and the stores.
   function automatic int unsigned eff_dim(logic [sem_pkg::CSR_W-1:0] raw);
      if (raw < sem_pkg::DIM_MIN) return sem_pkg::DIM_MIN;
      if (raw > MAX_DIM) return MAX_DIM;
      return 32'(raw);
   endfunction

   // Floor square root; the 8-bit search saturates at 255 by itself.
   function automatic logic [sem_pkg::PIX_W-1:0] root_floor(int unsigned sq);
      int unsigned trial;
      logic [sem_pkg::PIX_W-1:0] root;
      root = '0;
      for (int b = sem_pkg::PIX_W - 1; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= sq) root = trial[sem_pkg::PIX_W-1:0];
      end
      return root;
   endfunction

   // Shifts one pixel into the window and line stores. Returns 1 with the
   // magnitude word when the window lies wholly inside the frame.
   function automatic bit predict_magnitude(input logic [sem_pkg::PIX_W-1:0] pix,
                                            output edge_word_type word);
      int unsigned w, h, c, r, sq;
      int top, bot, lef, rig, gv, gh;
      bit produced;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      produced = 1'b0;
      word = '0;
      for (int k = 0; k < 3; k++) begin
         window[k*3]   = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2] = line_prev2[c];
      window[5] = line_prev[c];
      window[8] = pix;
      line_prev2[c] = line_prev[c];
      line_prev[c] = pix;
      if (r >= 2 && c >= 2) begin
         top = window[0] + 2 * window[1] + window[2];
         bot = window[6] + 2 * window[7] + window[8];
         lef = window[0] + 2 * window[3] + window[6];
         rig = window[2] + 2 * window[5] + window[8];
         gv = top - bot;
         gh = lef - rig;
         sq = gv * gv + gh * gh;
         word.magnitude = root_floor(sq);
         word.frame_end = (r == h - 1 && c == w - 1);
         produced = 1'b1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      return produced;
   endfunction

   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic step_type csr_row(logic [sem_pkg::CSR_IDX_W-1:0] idx,
                                        logic [sem_pkg::CSR_W-1:0] data);
      step_type row;
      row = '0;
      row.kind = STEP_CSR;
      row.index = idx;
      row.value = data;
      return row;
   endfunction

   function automatic step_type pixel_row(logic [sem_pkg::PIX_W-1:0] pix);
      step_type row;
      row = '0;
      row.kind = STEP_PIXEL;
      row.value = sem_pkg::CSR_W'(pix);
      return row;
   endfunction

   function automatic step_type pixel_row_typed(logic [sem_pkg::PIX_W-1:0] pix,
                                                logic [sem_pkg::PIX_W-1:0] mag,
                                                logic fe);
      step_type row;
      row = pixel_row(pix);
      row.typed = 1'b1;
      row.word.magnitude = mag;
      row.word.frame_end = fe;
      return row;
   endfunction

   // Waits until every predicted word has come back and the pipeline is quiet.
   task automatic wait_idle();
      while (magnitude_expected.size() != 0) @(negedge clock);
      repeat (IDLE_PAUSE) @(negedge clock);
   endtask

   // Register write on an idle block; a valid index also restarts the frame.
   task automatic write_csr(input logic [sem_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sem_pkg::CSR_W-1:0] data);
      @(negedge clock);
      req_push <= 1'b0;
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == sem_pkg::CSR_IMAGE_WIDTH || idx == sem_pkg::CSR_IMAGE_HEIGHT) begin
         if (idx == sem_pkg::CSR_IMAGE_WIDTH) width_reg = data;
         else height_reg = data;
         col_pos = 0;
         row_pos = 0;
      end
   endtask

   // Offers one pixel, after a random gap unless the feed is steady, and records what it should produce.
   task automatic send_pixel(input logic [sem_pkg::PIX_W-1:0] pix, input logic typed,
                             input edge_word_type typed_word);
      int gap;
      bit produced;
      edge_word_type predicted;
      @(negedge clock);
      gap = feed_steady ? 0 : idle_cycles();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_full !== 1'b0);
      produced = predict_magnitude(pix, predicted);
      if (typed) magnitude_expected.push_back(typed_word);
      else if (produced) magnitude_expected.push_back(predicted);
   endtask

   // Random pixels around a base level; the spread sets how strong the edges get.
   task automatic feed_pixels(input int count);
      int spread, base;
      logic [sem_pkg::PIX_W-1:0] pix;
      case ($urandom_range(0, 3))
         0: spread = 3;
         1: spread = 15;
         2: spread = 63;
         default: spread = 255;
      endcase
      base = $urandom_range(0, 255 - spread);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 15) == 0) pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else pix = sem_pkg::PIX_W'(base + $urandom_range(0, spread));
         send_pixel(pix, 1'b0, '0);
      end
   endtask

   // Result side: random gaps, steady stretches and two long hold-offs.
   initial begin : result_sink
      int idle;
      int steady_left;
      edge_word_type want;
      rsp_pop = 1'b0;
      steady_left = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (words_popped == 100 || words_popped == 200) begin
            idle = HOLD_CYCLES;
         end else if (steady_left > 0) begin
            idle = 0;
            steady_left--;
         end else begin
            idle = idle_cycles();
            if ($urandom_range(0, 39) == 0) steady_left = $urandom_range(20, 80);
         end
         if (idle > 0) begin
            rsp_pop <= 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         words_popped++;
         if (magnitude_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected word magnitude %0d frame_end %0b",
                        $time, rsp_magnitude, rsp_frame_end);
         end else begin
            want = magnitude_expected.pop_front();
            if (rsp_magnitude !== want.magnitude || rsp_frame_end !== want.frame_end) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: word %0d magnitude exp %0d got %0d, frame_end exp %0b got %0b",
                           $time, words_popped, want.magnitude, rsp_magnitude,
                           want.frame_end, rsp_frame_end);
            end
         end
      end
   end

   // Timeout guard.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int random_pixels, count, frame_pixels, pick;
      logic [sem_pkg::CSR_W-1:0] w_raw, h_raw;

      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = sem_pkg::CSR_IMAGE_WIDTH;
      csr_data = '0;
      req_push = 1'b0;
      req_pixel = '0;
      mismatch_count = 0;
      words_popped = 0;
      feed_steady = 1'b0;

      // Predictor reset state.
      width_reg = sem_pkg::WIDTH_RESET;
      height_reg = sem_pkg::HEIGHT_RESET;
      foreach (line_prev[i]) begin
         line_prev[i] = '0;
         line_prev2[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_pos = 0;
      row_pos = 0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset geometry: part of the first row, which yields no word.
      feed_pixels(40);

      // Directed rows: saturation both ways, clamped geometry, frame wrap,
      // and writes to unused indexes that must leave the frame running.
      directed_steps = '{
         csr_row(sem_pkg::CSR_IMAGE_WIDTH, 11'd3),
         csr_row(sem_pkg::CSR_IMAGE_HEIGHT, 11'd3),
         pixel_row(8'd255), pixel_row(8'd255), pixel_row(8'd255),
         pixel_row(8'd0), pixel_row(8'd0), pixel_row(8'd0),
         pixel_row(8'd0), pixel_row(8'd0),
         pixel_row_typed(8'd0, sem_pkg::MAG_MAX, 1'b1),
         csr_row(sem_pkg::CSR_IMAGE_WIDTH, 11'd0),
         csr_row(sem_pkg::CSR_IMAGE_HEIGHT, 11'd1),
         pixel_row(8'd0), pixel_row(8'd0), pixel_row(8'd0),
         pixel_row(8'd0), pixel_row(8'd0), pixel_row(8'd1),
         pixel_row(8'd0), pixel_row(8'd0), pixel_row(8'd2),
         pixel_row(8'd255), pixel_row(8'd0), pixel_row(8'd0),
         pixel_row(8'd255), pixel_row(8'd0), pixel_row(8'd0),
         pixel_row(8'd255),
         csr_row(CSR_UNUSED_2, 11'h7FF),
         csr_row(CSR_UNUSED_3, 11'd0),
         pixel_row(8'd0),
         pixel_row_typed(8'd0, sem_pkg::MAG_MAX, 1'b1)
      };
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            write_csr(directed_steps[i].index, directed_steps[i].value);
         else
            send_pixel(directed_steps[i].value[sem_pkg::PIX_W-1:0], directed_steps[i].typed,
                       directed_steps[i].word);
      end

      // Random frames of small geometry, mostly whole frames.
      random_pixels = 0;
      while (random_pixels < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 7);
         w_raw = ($urandom_range(0, 7) == 0) ? sem_pkg::CSR_W'($urandom_range(0, 2))
                                             : sem_pkg::CSR_W'($urandom_range(3, 12));
         h_raw = ($urandom_range(0, 7) == 0) ? sem_pkg::CSR_W'($urandom_range(0, 2))
                                             : sem_pkg::CSR_W'($urandom_range(3, 8));
         if (pick <= 3) begin
            if ($urandom_range(0, 1)) begin
               write_csr(sem_pkg::CSR_IMAGE_WIDTH, w_raw);
               write_csr(sem_pkg::CSR_IMAGE_HEIGHT, h_raw);
            end else begin
               write_csr(sem_pkg::CSR_IMAGE_HEIGHT, h_raw);
               write_csr(sem_pkg::CSR_IMAGE_WIDTH, w_raw);
            end
         end else if (pick <= 5) begin
            write_csr(sem_pkg::CSR_IMAGE_WIDTH, w_raw);
         end else if (pick == 6) begin
            write_csr(sem_pkg::CSR_IMAGE_HEIGHT, h_raw);
         end else begin
            write_csr(CSR_UNUSED_3, sem_pkg::CSR_W'($urandom_range(0, 2047)));
         end
         if ($urandom_range(0, 5) == 0)
            write_csr($urandom_range(0, 1) ? CSR_UNUSED_2 : CSR_UNUSED_3,
                      sem_pkg::CSR_W'($urandom_range(0, 2047)));
         frame_pixels = eff_dim(width_reg) * eff_dim(height_reg);
         if ($urandom_range(0, 3) != 0) count = frame_pixels * $urandom_range(1, 2);
         else count = $urandom_range(1, 2 * frame_pixels);
         feed_steady = ($urandom_range(0, 3) == 0);
         feed_pixels(count);
         feed_steady = 1'b0;
         random_pixels += count;
      end

      @(negedge clock);
      req_push <= 1'b0;
      wait_idle();
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
